### hw/rtl/assert_macros.svh
// Assertion macros shared by the sharpening filter RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks that a condition holds at every clock edge outside reset.
`define CKS_ASSERT(label, expr, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Checks that a condition implies another in the same cycle.
`define CKS_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Checks that a condition implies another in the following cycle.
`define CKS_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### hw/rtl/cks_pkg.sv
// Shared types and constants of the cross-kernel sharpening filter.
package cks_pkg;

  localparam int unsigned MAX_WIDTH_DEF    = 2048;
  localparam int unsigned MAX_CHANNELS_DEF = 4;

  localparam int unsigned SAMPLE_W    = 8;
  localparam int unsigned WIDTH_W     = 12;
  localparam int unsigned HEIGHT_W    = 16;
  localparam int unsigned CHAN_W      = 3;
  localparam int unsigned ROW_BYTES_W = 14;
  localparam int unsigned PADDR_W     = 4;
  localparam int unsigned PDATA_W     = 32;

  localparam int unsigned MIN_DIM     = 3;
  localparam int unsigned CENTER_GAIN = 5;
  localparam int unsigned OUTQ_DEPTH  = 4;

  localparam logic [WIDTH_W-1:0]  WIDTH_RST  = 12'd640;
  localparam logic [HEIGHT_W-1:0] HEIGHT_RST = 16'd480;
  localparam logic [CHAN_W-1:0]   CHAN_RST   = 3'd3;

  // Register indexes, taken from paddr[3:2].
  localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd0;
  localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd1;
  localparam logic [1:0] REG_CHANNEL_COUNT = 2'd2;

  // Effective (clamped) frame geometry plus a restart strobe.
  typedef struct packed {
    logic [WIDTH_W-1:0]     width;
    logic [HEIGHT_W-1:0]    height;
    logic [CHAN_W-1:0]      chans;
    logic [ROW_BYTES_W-1:0] row_bytes;
    logic                   restart;
  } cks_cfg_t;

  // One input's results: pair marks a last-row input that yields a trailing zero.
  typedef struct packed {
    logic [SAMPLE_W-1:0] sample;
    logic                pair;
    logic                fend;
  } cks_res_t;

endpackage

### hw/rtl/cks_regs.sv
// APB register file with clamping of the frame geometry.
module cks_regs #(
  parameter int unsigned MAX_WIDTH    = cks_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_CHANNELS = cks_pkg::MAX_CHANNELS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         psel,
  input  logic                         penable,
  input  logic                         pwrite,
  input  logic [cks_pkg::PADDR_W-1:0]  paddr,
  input  logic [cks_pkg::PDATA_W-1:0]  pwdata,
  output logic [cks_pkg::PDATA_W-1:0]  prdata,
  output logic                         pready,
  output cks_pkg::cks_cfg_t            cfg
);

  localparam int unsigned WIDTH_MAXV = (1 << cks_pkg::WIDTH_W) - 1;
  localparam int unsigned WIDTH_CAP  = (MAX_WIDTH > WIDTH_MAXV) ? WIDTH_MAXV : MAX_WIDTH;

  logic [cks_pkg::WIDTH_W-1:0]     width_r;
  logic [cks_pkg::HEIGHT_W-1:0]    height_r;
  logic [cks_pkg::CHAN_W-1:0]      chans_r;
  logic [1:0]                      idx;
  logic                            wr_en;
  logic [cks_pkg::WIDTH_W-1:0]     eff_w;
  logic [cks_pkg::HEIGHT_W-1:0]    eff_h;
  logic [cks_pkg::CHAN_W-1:0]      eff_ch;

  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite;
  assign pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r  <= cks_pkg::WIDTH_RST;
      height_r <= cks_pkg::HEIGHT_RST;
      chans_r  <= cks_pkg::CHAN_RST;
    end else if (wr_en) begin
      unique case (idx)
        cks_pkg::REG_IMAGE_WIDTH:   width_r  <= pwdata[cks_pkg::WIDTH_W-1:0];
        cks_pkg::REG_IMAGE_HEIGHT:  height_r <= pwdata[cks_pkg::HEIGHT_W-1:0];
        cks_pkg::REG_CHANNEL_COUNT: chans_r  <= pwdata[cks_pkg::CHAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    if (width_r < cks_pkg::WIDTH_W'(cks_pkg::MIN_DIM)) begin
      eff_w = cks_pkg::WIDTH_W'(cks_pkg::MIN_DIM);
    end else if (32'(width_r) > MAX_WIDTH) begin
      eff_w = cks_pkg::WIDTH_W'(WIDTH_CAP);
    end else begin
      eff_w = width_r;
    end

    if (height_r < cks_pkg::HEIGHT_W'(cks_pkg::MIN_DIM)) begin
      eff_h = cks_pkg::HEIGHT_W'(cks_pkg::MIN_DIM);
    end else begin
      eff_h = height_r;
    end

    if (chans_r == '0) begin
      eff_ch = cks_pkg::CHAN_W'(1);
    end else if (32'(chans_r) > MAX_CHANNELS) begin
      eff_ch = cks_pkg::CHAN_W'(MAX_CHANNELS);
    end else begin
      eff_ch = chans_r;
    end
  end

  always_comb begin
    unique case (idx)
      cks_pkg::REG_IMAGE_WIDTH:   prdata = cks_pkg::PDATA_W'(width_r);
      cks_pkg::REG_IMAGE_HEIGHT:  prdata = cks_pkg::PDATA_W'(height_r);
      cks_pkg::REG_CHANNEL_COUNT: prdata = cks_pkg::PDATA_W'(chans_r);
      default:                    prdata = '0;
    endcase
  end

  // Any write to a defined register restarts the frame position.
  assign cfg.width     = eff_w;
  assign cfg.height    = eff_h;
  assign cfg.chans     = eff_ch;
  assign cfg.row_bytes = cks_pkg::ROW_BYTES_W'(cks_pkg::ROW_BYTES_W'(eff_w) *
                                               cks_pkg::ROW_BYTES_W'(eff_ch));
  assign cfg.restart   = wr_en && (idx <= cks_pkg::REG_CHANNEL_COUNT);

endmodule

### hw/rtl/cks_engine.sv
// Line stores, position counters and the cross-kernel arithmetic.
module cks_engine #(
  parameter int unsigned MAX_WIDTH    = cks_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_CHANNELS = cks_pkg::MAX_CHANNELS_DEF
) (
  input  logic                                        clk,
  input  logic                                        rst_n,
  input  cks_pkg::cks_cfg_t                           cfg,
  input  logic                                        in_valid,
  output logic                                        in_stall,
  input  logic [cks_pkg::SAMPLE_W-1:0]                in_sample_in,
  input  logic [$clog2(cks_pkg::OUTQ_DEPTH+1)-1:0]    q_count,
  output logic                                        res_valid,
  output cks_pkg::cks_res_t                           res
);

  localparam int unsigned DEPTH = MAX_WIDTH * MAX_CHANNELS;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(MAX_WIDTH);
  localparam int unsigned CHW   = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
  localparam int unsigned QCW   = $clog2(cks_pkg::OUTQ_DEPTH + 1);
  localparam int unsigned SW    = cks_pkg::SAMPLE_W;
  localparam int unsigned HW    = cks_pkg::HEIGHT_W;
  localparam int unsigned POS_W = SW + 3;
  localparam int unsigned NEG_W = SW + 2;
  localparam int unsigned ACC_W = SW + 4;

  // Position of the next input.
  logic [AW-1:0]  byte_r;
  logic [CW-1:0]  col_r;
  logic [CHW-1:0] chan_r;
  logic [HW-1:0]  row_r;

  // Second stage: the accepted sample while its store reads return.
  logic           vb_r;
  logic [SW-1:0]  s_b_r;
  logic [AW-1:0]  addr_b_r;
  logic           first_row_b_r;
  logic           border_b_r;
  logic           last_row_b_r;
  logic           fend_b_r;

  logic [SW-1:0]  mid_mem [DEPTH];
  logic [SW-1:0]  old_mem [DEPTH];
  logic [SW-1:0]  mid_rd0_r;
  logic [SW-1:0]  mid_rd1_r;
  logic [SW-1:0]  old_rd_r;
  logic [SW-1:0]  win_r [MAX_CHANNELS];

  logic           accept;
  logic [CHW-1:0] ch_m1;
  logic [AW-1:0]  rb_m1;
  logic [CW-1:0]  w_m1;
  logic [HW-1:0]  h_m1;
  logic           last_byte;
  logic           last_chan;
  logic           last_row;
  logic [AW-1:0]  right_addr;

  logic [SW-1:0]            center;
  logic [SW-1:0]            left;
  logic [POS_W-1:0]         pos;
  logic [NEG_W-1:0]         neg;
  logic signed [ACC_W-1:0]  acc;
  logic [SW-1:0]            clamped;

  assign in_stall = ((QCW+1)'(q_count) + (QCW+1)'(vb_r)) >= (QCW+1)'(cks_pkg::OUTQ_DEPTH);
  assign accept   = in_valid && !in_stall;

  assign ch_m1     = CHW'(cfg.chans - cks_pkg::CHAN_W'(1));
  assign rb_m1     = AW'(cfg.row_bytes - cks_pkg::ROW_BYTES_W'(1));
  assign w_m1      = CW'(cfg.width - cks_pkg::WIDTH_W'(1));
  assign h_m1      = cfg.height - HW'(1);
  assign last_byte = (byte_r == rb_m1);
  assign last_chan = (chan_r == ch_m1);
  assign last_row  = (row_r == h_m1);

  // Beyond the last column this address runs past the row; its data is never used there.
  assign right_addr = AW'((AW+1)'(byte_r) + (AW+1)'(cfg.chans));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byte_r <= '0;
      col_r  <= '0;
      chan_r <= '0;
      row_r  <= '0;
      vb_r   <= 1'b0;
    end else begin
      vb_r <= accept;
      if (cfg.restart) begin
        byte_r <= '0;
        col_r  <= '0;
        chan_r <= '0;
        row_r  <= '0;
      end else if (accept) begin
        if (last_byte) begin
          byte_r <= '0;
          col_r  <= '0;
          chan_r <= '0;
          row_r  <= last_row ? '0 : row_r + HW'(1);
        end else begin
          byte_r <= byte_r + AW'(1);
          if (last_chan) begin
            chan_r <= '0;
            col_r  <= col_r + CW'(1);
          end else begin
            chan_r <= chan_r + CHW'(1);
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s_b_r         <= in_sample_in;
      addr_b_r      <= byte_r;
      first_row_b_r <= (row_r == '0);
      border_b_r    <= (row_r == HW'(1)) || (col_r == '0) || (col_r == w_m1);
      last_row_b_r  <= last_row;
      fend_b_r      <= last_row && last_byte;
    end
  end

  // The write-back of one sample never meets the reads of the next, since a row
  // holds at least three samples; the stores need no forwarding.
  always_ff @(posedge clk) begin
    mid_rd0_r <= mid_mem[byte_r];
    mid_rd1_r <= mid_mem[right_addr];
    old_rd_r  <= old_mem[byte_r];
    if (vb_r) begin
      mid_mem[addr_b_r] <= s_b_r;
    end
    if (vb_r && !first_row_b_r) begin
      old_mem[addr_b_r] <= mid_rd0_r;
    end
  end

  // Recent centres of the middle row; the same channel one pixel back sits
  // one channel count behind.
  always_ff @(posedge clk) begin
    if (vb_r && !first_row_b_r) begin
      win_r[0] <= mid_rd0_r;
      for (int i = 1; i < MAX_CHANNELS; i++) begin
        win_r[i] <= win_r[i-1];
      end
    end
  end

  assign center = mid_rd0_r;
  assign left   = win_r[ch_m1];

  always_comb begin
    pos = POS_W'(center) * POS_W'(cks_pkg::CENTER_GAIN);
    neg = NEG_W'(left) + NEG_W'(mid_rd1_r) + NEG_W'(old_rd_r) + NEG_W'(s_b_r);
    acc = $signed(ACC_W'(pos)) - $signed(ACC_W'(neg));
    if (acc < 0) begin
      clamped = '0;
    end else if (acc > $signed(ACC_W'({SW{1'b1}}))) begin
      clamped = '1;
    end else begin
      clamped = acc[SW-1:0];
    end
  end

  assign res_valid  = vb_r && !first_row_b_r;
  assign res.sample = border_b_r ? '0 : clamped;
  assign res.pair   = last_row_b_r;
  assign res.fend   = fend_b_r;

endmodule

### hw/rtl/cks_outq.sv
// Result queue that splits last-row entries into their two output transactions.
module cks_outq (
  input  logic                                      clk,
  input  logic                                      rst_n,
  input  logic                                      push,
  input  cks_pkg::cks_res_t                         push_data,
  output logic [$clog2(cks_pkg::OUTQ_DEPTH+1)-1:0]  count,
  output logic                                      out_valid,
  input  logic                                      out_stall,
  output logic [cks_pkg::SAMPLE_W-1:0]              out_sample_out,
  output logic                                      out_run_last,
  output logic                                      out_frame_end
);

  localparam int unsigned QD  = cks_pkg::OUTQ_DEPTH;
  localparam int unsigned PW  = $clog2(QD);
  localparam int unsigned QCW = $clog2(QD + 1);

  cks_pkg::cks_res_t q_r [QD];
  logic [PW-1:0]     wr_ptr_r;
  logic [PW-1:0]     rd_ptr_r;
  logic [QCW-1:0]    count_r;
  logic [QCW-1:0]    count_nxt;
  logic              phase_r;
  cks_pkg::cks_res_t head;
  logic              second;
  logic              beat;
  logic              pop;

  assign head      = q_r[rd_ptr_r];
  assign second    = head.pair && phase_r;
  assign out_valid = (count_r != '0);

  assign out_sample_out = second ? '0 : head.sample;
  assign out_run_last   = !head.pair || phase_r;
  assign out_frame_end  = second && head.fend;

  assign beat      = out_valid && !out_stall;
  assign pop       = beat && out_run_last;
  assign count_nxt = count_r + QCW'(push) - QCW'(pop);
  assign count     = count_r;

  always_ff @(posedge clk) begin
    if (push) begin
      q_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
      phase_r  <= 1'b0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PW'(QD - 1)) ? '0 : wr_ptr_r + PW'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PW'(QD - 1)) ? '0 : rd_ptr_r + PW'(1);
        phase_r  <= 1'b0;
      end else if (beat) begin
        phase_r  <= 1'b1;
      end
    end
  end

endmodule

### hw/rtl/cross_kernel_sharpen_3x3.sv
// Cross-kernel 3x3 sharpening filter for an interleaved 8-bit sample stream.
// An accepted sample passes the second-stage registers and then the result queue before
// its result is offered. Throughput: one sample per cycle while the result queue has room,
// set by the single read-modify-write pass through the two line stores; last-row inputs give two results each.
// Reset: geometry returns to 640x480 with 3 channels and the position to the frame
// start; the line stores are not cleared and hold data only once written.
`include "assert_macros.svh"

module cross_kernel_sharpen_3x3 #(
  parameter int unsigned MAX_WIDTH    = cks_pkg::MAX_WIDTH_DEF,
  parameter int unsigned MAX_CHANNELS = cks_pkg::MAX_CHANNELS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [cks_pkg::PADDR_W-1:0]   paddr,
  input  logic [cks_pkg::PDATA_W-1:0]   pwdata,
  output logic [cks_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [cks_pkg::SAMPLE_W-1:0]  in_sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [cks_pkg::SAMPLE_W-1:0]  out_sample_out,
  output logic                          out_run_last,
  output logic                          out_frame_end
);

  cks_pkg::cks_cfg_t                         cfg;
  cks_pkg::cks_res_t                         res;
  logic                                      res_valid;
  logic [$clog2(cks_pkg::OUTQ_DEPTH+1)-1:0]  q_count;

  cks_regs #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  cks_engine #(
    .MAX_WIDTH    (MAX_WIDTH),
    .MAX_CHANNELS (MAX_CHANNELS)
  ) u_engine (
    .clk          (clk),
    .rst_n        (rst_n),
    .cfg          (cfg),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_sample_in (in_sample_in),
    .q_count      (q_count),
    .res_valid    (res_valid),
    .res          (res)
  );

  cks_outq u_outq (
    .clk            (clk),
    .rst_n          (rst_n),
    .push           (res_valid),
    .push_data      (res),
    .count          (q_count),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_sample_out (out_sample_out),
    .out_run_last   (out_run_last),
    .out_frame_end  (out_frame_end)
  );

  // The frame ends only on the trailing zero of a last-row input.
  `CKS_ASSERT_IMPL(a_fend_is_last, out_valid && out_frame_end, out_run_last, "frame end without run last")
  `CKS_ASSERT_IMPL(a_fend_is_zero, out_valid && out_frame_end, out_sample_out == '0, "frame end with nonzero sample")
  // The trailing zero stays queued behind its partner transaction.
  `CKS_ASSERT_NEXT(a_pair_follows, out_valid && !out_run_last, out_valid, "second result of a pair missing")

endmodule
